>>> rtl/linked_list_node_pool_assert.svh
// assertion macros for the linked list node pool
// used by the control module; needs clk and arst_n in scope
`ifndef LINKED_LIST_NODE_POOL_ASSERT_SVH
`define LINKED_LIST_NODE_POOL_ASSERT_SVH
`ifndef ASSERT_OFF
`define LLNP_ASSERT_IMPL(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) else $error(msg);
`define LLNP_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);
`else
`define LLNP_ASSERT_IMPL(lbl, pre, post, msg)
`define LLNP_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

>>> rtl/llnp_pkg.sv
// shared types and codes for the linked list node pool
// no dependencies
package llnp_pkg;

	localparam int HANDLE_BITS = 8;

	typedef enum logic [2:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_BACK  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_INSERT     = 3'd3,
		OP_READ       = 3'd4,
		OP_WRITE      = 3'd5,
		OP_QUERY      = 3'd6,
		OP_SPARE      = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2,
		ST_BAD   = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE, S_DECODE, S_ALLOC, S_GETPREV, S_PREVW, S_LINK1, S_LINK2,
		S_POPW, S_RDW, S_FRONT, S_BACK, S_DONE, S_OUT
	} state_t;

	// one port of a link memory
	typedef struct packed {
		logic                   we;
		logic [HANDLE_BITS-1:0] waddr;
		logic [HANDLE_BITS-1:0] wdata;
		logic [HANDLE_BITS-1:0] raddr;
	} link_req_t;

	typedef struct packed {
		status_t                status;
		logic [31:0]            read_value;
		logic [HANDLE_BITS-1:0] node_handle;
		logic [HANDLE_BITS-1:0] first_handle;
		logic [31:0]            front_value;
		logic [31:0]            back_value;
		logic                   is_empty;
		logic [7:0]             item_count;
	} result_t;

endpackage

>>> rtl/llnp_store.sv
// node memories: data, forward links, backward links and the free stack
// one write and one registered read per memory per cycle; uses llnp_pkg
module llnp_store #(
	parameter int HLIM = 256,
	parameter int VB   = 32
) (
	input  logic                                clk,
	input  llnp_pkg::link_req_t                 next_req,
	input  llnp_pkg::link_req_t                 prev_req,
	input  llnp_pkg::link_req_t                 free_req,
	input  logic                                data_we,
	input  logic [llnp_pkg::HANDLE_BITS-1:0]    data_waddr,
	input  logic [VB-1:0]                       data_wdata,
	input  logic [llnp_pkg::HANDLE_BITS-1:0]    data_raddr,
	output logic [llnp_pkg::HANDLE_BITS-1:0]    next_rdata,
	output logic [llnp_pkg::HANDLE_BITS-1:0]    prev_rdata,
	output logic [llnp_pkg::HANDLE_BITS-1:0]    free_rdata,
	output logic [VB-1:0]                       data_rdata
);
	import llnp_pkg::*;

	localparam int HW = (HLIM > 1) ? $clog2(HLIM) : 1;

	logic [HANDLE_BITS-1:0] next_mem [HLIM];
	logic [HANDLE_BITS-1:0] prev_mem [HLIM];
	logic [HANDLE_BITS-1:0] free_mem [HLIM];
	logic [VB-1:0]          data_mem [HLIM];

	// forward links
	always_ff @(posedge clk) begin
		if (next_req.we) begin
			next_mem[next_req.waddr[HW-1:0]] <= next_req.wdata;
		end
		next_rdata <= next_mem[next_req.raddr[HW-1:0]];
	end

	// backward links
	always_ff @(posedge clk) begin
		if (prev_req.we) begin
			prev_mem[prev_req.waddr[HW-1:0]] <= prev_req.wdata;
		end
		prev_rdata <= prev_mem[prev_req.raddr[HW-1:0]];
	end

	// free stack
	always_ff @(posedge clk) begin
		if (free_req.we) begin
			free_mem[free_req.waddr[HW-1:0]] <= free_req.wdata;
		end
		free_rdata <= free_mem[free_req.raddr[HW-1:0]];
	end

	// node values
	always_ff @(posedge clk) begin
		if (data_we) begin
			data_mem[data_waddr[HW-1:0]] <= data_wdata;
		end
		data_rdata <= data_mem[data_raddr[HW-1:0]];
	end

endmodule

>>> rtl/llnp_ctrl.sv
// operation sequencer: list head registers, in-use bits, allocation
// drives llnp_store; uses llnp_pkg and the assertion macro header
`include "linked_list_node_pool_assert.svh"
module llnp_ctrl #(
	parameter int HLIM = 256,
	parameter int VB   = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [2:0]                       in_op,
	input  logic [31:0]                      in_value,
	input  logic [llnp_pkg::HANDLE_BITS-1:0] in_handle,
	output logic                             res_valid,
	input  logic                             res_ready,
	output llnp_pkg::result_t                res,
	output llnp_pkg::link_req_t              next_req,
	output llnp_pkg::link_req_t              prev_req,
	output llnp_pkg::link_req_t              free_req,
	output logic                             data_we,
	output logic [llnp_pkg::HANDLE_BITS-1:0] data_waddr,
	output logic [VB-1:0]                    data_wdata,
	output logic [llnp_pkg::HANDLE_BITS-1:0] data_raddr,
	input  logic [llnp_pkg::HANDLE_BITS-1:0] next_rdata,
	input  logic [llnp_pkg::HANDLE_BITS-1:0] prev_rdata,
	input  logic [llnp_pkg::HANDLE_BITS-1:0] free_rdata,
	input  logic [VB-1:0]                    data_rdata
);
	import llnp_pkg::*;

	localparam int HW = (HLIM > 1) ? $clog2(HLIM) : 1;
	localparam logic [8:0] HLIM9 = 9'(HLIM);

	// stored value sign extended or cut to the 32-bit result field
	function automatic logic [31:0] ext_out(input logic [VB-1:0] d);
		logic [31:0] r;
		for (int i = 0; i < 32; i++) begin
			r[i] = d[(i < VB) ? i : VB - 1];
		end
		return r;
	endfunction

	// 32-bit input sign extended or cut to the stored width
	function automatic logic [VB-1:0] ext_in(input logic [31:0] d);
		logic [VB-1:0] r;
		for (int i = 0; i < VB; i++) begin
			r[i] = d[(i < 32) ? i : 31];
		end
		return r;
	endfunction

	state_t                 state_q, state_d;
	op_t                    op_q;
	logic [VB-1:0]          val_q;
	logic [HANDLE_BITS-1:0] h_q, n_q, a_q, b_q;
	logic [HANDLE_BITS-1:0] first_q, last_q, free_top_q;
	logic [8:0]             fresh_q;
	logic [7:0]             count_q;
	logic                   in_use_q [HLIM];
	logic                   use_q;
	status_t                status_q;
	logic [31:0]            rd_q, front_q, back_q;
	logic [HANDLE_BITS-1:0] nh_q;

	logic                   accept, empty, h_in_pool, h_node, h_zero;
	logic                   push_op, insert_bad, from_free, from_fresh;
	logic [HANDLE_BITS-1:0] at;

	// decode helpers
	assign accept     = in_valid && in_ready;
	assign empty      = (count_q == 8'd0);
	assign h_zero     = (h_q == '0);
	assign h_in_pool  = ({1'b0, h_q} < HLIM9);
	assign h_node     = !h_zero && h_in_pool && use_q;
	assign push_op    = (op_q == OP_PUSH_FRONT) || (op_q == OP_PUSH_BACK) ||
	                    (op_q == OP_INSERT);
	assign insert_bad = (op_q == OP_INSERT) && !h_zero && !h_node;
	assign from_free  = (free_top_q != '0);
	assign from_fresh = (fresh_q < HLIM9);

	always_comb begin
		case (op_q)
			OP_PUSH_FRONT: at = first_q;
			OP_PUSH_BACK:  at = '0;
			default:       at = h_q;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:    if (in_valid) state_d = S_DECODE;
			S_DECODE: begin
				state_d = S_FRONT;
				case (op_q)
					OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT: begin
						if (!insert_bad && from_free) state_d = S_ALLOC;
						else if (!insert_bad && from_fresh) state_d = S_GETPREV;
					end
					OP_POP_FRONT: if (!empty) state_d = S_POPW;
					OP_READ:      if (!empty && h_node) state_d = S_RDW;
					default:      state_d = S_FRONT;
				endcase
			end
			S_ALLOC:   state_d = S_GETPREV;
			S_GETPREV: state_d = (at == '0) ? S_LINK1 : S_PREVW;
			S_PREVW:   state_d = S_LINK1;
			S_LINK1:   state_d = S_LINK2;
			S_LINK2:   state_d = S_FRONT;
			S_POPW:    state_d = S_FRONT;
			S_RDW:     state_d = S_FRONT;
			S_FRONT:   state_d = S_BACK;
			S_BACK:    state_d = S_DONE;
			S_DONE:    state_d = S_OUT;
			S_OUT:     if (res_ready) state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	// memory ports and handshake outputs
	always_comb begin
		in_ready   = (state_q == S_IDLE);
		res_valid  = (state_q == S_OUT);
		next_req   = '0;
		prev_req   = '0;
		free_req   = '0;
		data_we    = 1'b0;
		data_waddr = '0;
		data_wdata = val_q;
		data_raddr = '0;
		case (state_q)
			S_DECODE: begin
				free_req.raddr = free_top_q - 1'b1;
				next_req.raddr = (op_q == OP_POP_FRONT) ? first_q : h_q;
				data_raddr     = h_q;
				data_waddr     = h_q;
				data_we        = (op_q == OP_WRITE) && !empty && h_node;
			end
			S_GETPREV: prev_req.raddr = at;
			S_LINK1: begin
				data_we        = 1'b1;
				data_waddr     = n_q;
				next_req.we    = 1'b1;
				next_req.waddr = n_q;
				next_req.wdata = b_q;
				prev_req.we    = 1'b1;
				prev_req.waddr = n_q;
				prev_req.wdata = a_q;
			end
			S_LINK2: begin
				next_req.we    = (a_q != '0);
				next_req.waddr = a_q;
				next_req.wdata = n_q;
				prev_req.we    = (b_q != '0);
				prev_req.waddr = b_q;
				prev_req.wdata = n_q;
			end
			S_POPW: begin
				prev_req.we    = (next_rdata != '0);
				prev_req.waddr = next_rdata;
				prev_req.wdata = '0;
				free_req.we    = 1'b1;
				free_req.waddr = free_top_q;
				free_req.wdata = first_q;
			end
			S_FRONT: data_raddr = first_q;
			S_BACK:  data_raddr = last_q;
			default: data_raddr = '0;
		endcase
	end

	// sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			first_q    <= '0;
			last_q     <= '0;
			free_top_q <= '0;
			fresh_q    <= 9'd1;
			count_q    <= '0;
			for (int i = 0; i < HLIM; i++) in_use_q[i] <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_DECODE: begin
					if (push_op && !insert_bad) begin
						if (from_free) free_top_q <= free_top_q - 1'b1;
						else if (from_fresh) fresh_q <= fresh_q + 9'd1;
					end
				end
				S_LINK1: begin
					in_use_q[n_q[HW-1:0]] <= 1'b1;
					count_q <= count_q + 8'd1;
				end
				S_LINK2: begin
					if (a_q == '0) first_q <= n_q;
					if (b_q == '0) last_q <= n_q;
				end
				S_POPW: begin
					first_q <= next_rdata;
					if (next_rdata == '0) last_q <= '0;
					in_use_q[first_q[HW-1:0]] <= 1'b0;
					free_top_q <= free_top_q + 1'b1;
					count_q <= count_q - 8'd1;
				end
				default: ;
			endcase
		end
	end

	// operation and result payload
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				op_q     <= op_t'(in_op);
				val_q    <= ext_in(in_value);
				h_q      <= in_handle;
				use_q    <= in_use_q[in_handle[HW-1:0]];
				status_q <= ST_OK;
				rd_q     <= '0;
				nh_q     <= '0;
			end
			S_DECODE: begin
				n_q <= fresh_q[HANDLE_BITS-1:0];
				case (op_q)
					OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT: begin
						if (insert_bad) status_q <= ST_BAD;
						else if (!from_free && !from_fresh) status_q <= ST_FULL;
					end
					OP_POP_FRONT: if (empty) status_q <= ST_EMPTY;
					OP_READ, OP_WRITE: begin
						if (empty) status_q <= ST_EMPTY;
						else if (!h_node) status_q <= ST_BAD;
					end
					default: ;
				endcase
			end
			S_ALLOC:   n_q <= free_rdata;
			S_GETPREV: begin
				b_q <= at;
				a_q <= last_q;
			end
			S_PREVW:   a_q <= prev_rdata;
			S_LINK1:   nh_q <= n_q;
			S_RDW: begin
				rd_q <= ext_out(data_rdata);
				nh_q <= next_rdata;
			end
			S_BACK:    front_q <= empty ? '0 : ext_out(data_rdata);
			S_DONE:    back_q <= empty ? '0 : ext_out(data_rdata);
			default: ;
		endcase
	end

	always_comb begin
		res.status       = status_q;
		res.read_value   = rd_q;
		res.node_handle  = nh_q;
		res.first_handle = first_q;
		res.front_value  = front_q;
		res.back_value   = back_q;
		res.is_empty     = empty;
		res.item_count   = count_q;
	end

	`LLNP_ASSERT_IMPL(a_head_empty, state_q != S_LINK2, empty == (first_q == '0) && empty == (last_q == '0), "head links disagree with count")
	`LLNP_ASSERT_IMPL(a_fresh_range, 1'b1, fresh_q <= HLIM9, "fresh pointer past pool")
	`LLNP_ASSERT_IMPL(a_new_unused, state_q == S_LINK1, !in_use_q[n_q[HW-1:0]] && n_q != '0, "allocated node already linked")
	`LLNP_ASSERT_NEXT(a_accept_decode, accept, state_q == S_DECODE, "accepted transfer not decoded")

endmodule

>>> rtl/linked_list_node_pool.sv
// a result is offered once the sequencer has done its node memory accesses
// (link updates, front and back reads); each memory has one write and one read port
// items are taken one at a time
// reset (arst_n low) empties the list and free stack at once; no clearing pass
// a finished result waits in the output register while the next item is taken
module linked_list_node_pool #(
	parameter int NODE_COUNT = 256,
	parameter int VALUE_BITS = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [47:0]  s_tdata,  // op[2:0], value[34:3], handle[42:35], zero fill
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata   // status, read_value, node_handle, first_handle,
	                               // front_value, back_value, is_empty, item_count
);
	import llnp_pkg::*;

	localparam int HLIM = (NODE_COUNT < 256) ? NODE_COUNT : 256;

	link_req_t              next_req, prev_req, free_req;
	logic                   data_we;
	logic [HANDLE_BITS-1:0] data_waddr, data_raddr;
	logic [VALUE_BITS-1:0]  data_wdata, data_rdata;
	logic [HANDLE_BITS-1:0] next_rdata, prev_rdata, free_rdata;
	logic                   res_valid, res_ready;
	result_t                res;
	logic                   out_valid_q;
	result_t                out_q;

	llnp_ctrl #(.HLIM(HLIM), .VB(VALUE_BITS)) u_ctrl (
		.clk, .arst_n,
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_op    (s_tdata[2:0]),
		.in_value (s_tdata[34:3]),
		.in_handle(s_tdata[42:35]),
		.res_valid, .res_ready, .res,
		.next_req, .prev_req, .free_req,
		.data_we, .data_waddr, .data_wdata, .data_raddr,
		.next_rdata, .prev_rdata, .free_rdata, .data_rdata
	);

	llnp_store #(.HLIM(HLIM), .VB(VALUE_BITS)) u_store (
		.clk,
		.next_req, .prev_req, .free_req,
		.data_we, .data_waddr, .data_wdata, .data_raddr,
		.next_rdata, .prev_rdata, .free_rdata, .data_rdata
	);

	// output register
	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'd0, out_q.item_count, out_q.is_empty, out_q.back_value,
	                   out_q.front_value, out_q.first_handle, out_q.node_handle,
	                   out_q.read_value, out_q.status};

endmodule
